// ----- rtl/pqa_pkg.sv -----
// ----------------------------------------------------------------------------
// pqa_pkg
// Shared types and constants of the priority queue with aging: transfer
// payloads, stored entry layout, status and action codes, aging rule.
// ----------------------------------------------------------------------------
package pqa_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ThrWidth     = 4;
  localparam int unsigned AgeWidth     = 4;

  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  localparam logic [1:0] StatusInserted    = 2'd0;
  localparam logic [1:0] StatusRemoved     = 2'd1;
  localparam logic [1:0] StatusRemoveEmpty = 2'd2;
  localparam logic [1:0] StatusInsertFull  = 2'd3;

  localparam logic [ThrWidth-1:0] ThrReset = ThrWidth'(1);

  typedef struct packed {
    logic       action;
    logic [7:0] req_id;
    logic [7:0] req_priority;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic [4:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [7:0]          tag;
    logic [7:0]          prio;
    logic [AgeWidth-1:0] age;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // entry overtaken by an insert: promote when due, otherwise count up
  function automatic entry_t age_entry(entry_t e, logic [ThrWidth-1:0] thr);
    entry_t r;
    r = e;
    if (AgeWidth'(e.age) >= AgeWidth'(thr)) begin
      if (e.prio != 8'hFF) begin
        r.prio = e.prio + 8'd1;
      end
      r.age = '0;
    end else begin
      r.age = e.age + AgeWidth'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/priority_queue_with_aging_top.sv -----
// ----------------------------------------------------------------------------
// priority_queue_with_aging_top
// Bounded ordered request queue held in a circular buffer RAM. An insert
// ripples the entries behind its slot back by one and ages them on the way.
//
//   channel  dir  handshake            payload
//   in       in   in_valid_i/in_stall_o    in_data_i   (pqa_pkg::in_t)
//   out      out  out_valid_o/out_stall_i  out_data_o  (pqa_pkg::out_t)
//   cfg      in   cfg_we_i             cfg_wdata_i (aging threshold)
//
// insert into n > 0 held entries: Scan per entry, Tail, Done; one RAM read per
// entry, writes from its slot on; remove: Pop, Done; empty or rejected: Done
// one item in flight; in_stall_o is high until its result is in the output
// register, which takes the next result only once the previous one is gone
// reset empties the queue and sets the threshold to 1; RAM is not cleared
// ----------------------------------------------------------------------------
module priority_queue_with_aging_top #(
  parameter int unsigned Depth = pqa_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pqa_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pqa_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pqa_pkg::ThrWidth-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StTail,
    StPop,
    StDone
  } state_e;

  state_e                        state_q;
  pqa_pkg::in_t                  req_q;
  logic [AW-1:0]                 head_q;
  logic [AW-1:0]                 rptr_q;
  logic [AW-1:0]                 wptr_q;
  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 left_q;
  logic                          found_q;
  pqa_pkg::entry_t               carry_q;
  pqa_pkg::out_t                 res_q;
  pqa_pkg::out_t                 out_q;
  logic                          out_valid_q;
  logic [pqa_pkg::ThrWidth-1:0]  thr_q;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  pqa_pkg::entry_t               ram_wdata;
  pqa_pkg::entry_t               ram_rdata;
  logic [pqa_pkg::EntryWidth-1:0] ram_rdata_raw;

  logic                          in_xfer;
  logic                          hit;
  logic                          out_free;
  pqa_pkg::entry_t               new_entry;
  pqa_pkg::entry_t               first_entry;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  pqa_ram #(
    .Width (pqa_pkg::EntryWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pqa_pkg::entry_t'(ram_rdata_raw);

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign new_entry   = '{tag: req_q.req_id, prio: req_q.req_priority, age: '0};
  assign first_entry = '{tag: in_data_i.req_id, prio: in_data_i.req_priority, age: '0};
  assign hit         = !found_q && (ram_rdata.prio <= req_q.req_priority);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr_q;
    ram_wdata = carry_q;
    ram_raddr = (state_q == StIdle) ? head_q : rptr_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && in_data_i.action == pqa_pkg::ActInsert && count_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = head_q;
          ram_wdata = first_entry;
        end
      end
      StScan: begin
        if (found_q) begin
          ram_we = 1'b1;
        end else if (hit) begin
          ram_we    = 1'b1;
          ram_wdata = new_entry;
        end
      end
      StTail: begin
        ram_we    = 1'b1;
        ram_wdata = found_q ? carry_q : new_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      head_q      <= '0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      count_q     <= '0;
      left_q      <= '0;
      found_q     <= 1'b0;
      carry_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= pqa_pkg::ThrReset;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            req_q <= in_data_i;
            if (in_data_i.action == pqa_pkg::ActRemove) begin
              if (count_q == '0) begin
                res_q   <= '{status: pqa_pkg::StatusRemoveEmpty, out_id: '0,
                             out_priority: '0, occupancy: '0};
                state_q <= StDone;
              end else begin
                res_q   <= '0;
                state_q <= StPop;
              end
            end else if (count_q == CW'(Depth)) begin
              res_q   <= '{status: pqa_pkg::StatusInsertFull, out_id: '0,
                           out_priority: '0, occupancy: '0};
              state_q <= StDone;
            end else if (count_q == '0) begin
              count_q <= CW'(1);
              res_q   <= '{status: pqa_pkg::StatusInserted, out_id: '0,
                           out_priority: '0, occupancy: '0};
              state_q <= StDone;
            end else begin
              res_q   <= '0;
              rptr_q  <= ptr_inc(head_q);
              wptr_q  <= head_q;
              left_q  <= count_q;
              found_q <= 1'b0;
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (found_q || hit) begin
            found_q <= 1'b1;
            carry_q <= pqa_pkg::age_entry(ram_rdata, thr_q);
          end
          rptr_q <= ptr_inc(rptr_q);
          wptr_q <= ptr_inc(wptr_q);
          left_q <= left_q - CW'(1);
          if (left_q == CW'(1)) begin
            state_q <= StTail;
          end
        end
        StTail: begin
          count_q      <= count_q + CW'(1);
          res_q.status <= pqa_pkg::StatusInserted;
          state_q      <= StDone;
        end
        StPop: begin
          res_q.status       <= pqa_pkg::StatusRemoved;
          res_q.out_id       <= ram_rdata.tag;
          res_q.out_priority <= ram_rdata.prio;
          head_q             <= ptr_inc(head_q);
          count_q            <= count_q - CW'(1);
          state_q            <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_q.status       <= res_q.status;
            out_q.out_id       <= res_q.out_id;
            out_q.out_priority <= res_q.out_priority;
            out_q.occupancy    <= 5'(count_q);
            out_valid_q        <= 1'b1;
            state_q            <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pqa_ram.sv -----
// ----------------------------------------------------------------------------
// pqa_ram
// Generic simple dual-port RAM: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
module pqa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sv/pqa_queue_checker.sv -----
// ----------------------------------------------------------------------------
// pqa_queue_checker
// Watches the request, result and threshold ports of the priority queue with
// aging. Keeps its own copy of the ordered entries and the aging threshold,
// works out the result of every accepted request and compares each accepted
// result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module pqa_queue_checker #(
  parameter int unsigned Depth = pqa_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  pqa_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  pqa_pkg::out_t                out_data_i,
  input  logic                         cfg_we_i,
  input  logic [pqa_pkg::ThrWidth-1:0] cfg_wdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import pqa_pkg::*;

  entry_t              held [Depth];
  int                  held_count = 0;
  logic [ThrWidth-1:0] threshold  = ThrReset;
  out_t                predicted_results [$];
  out_t                oldest;
  int                  mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic out_t serve_request(in_t req);
    out_t res;
    int   slot;
    res = '0;
    if (req.action == ActRemove) begin
      if (held_count == 0) begin
        res.status = StatusRemoveEmpty;
      end else begin
        res.status       = StatusRemoved;
        res.out_id       = held[0].tag;
        res.out_priority = held[0].prio;
        for (int i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
      end
    end else if (held_count >= int'(Depth)) begin
      res.status = StatusInsertFull;
    end else begin
      // first slot from the head whose priority does not exceed the new one
      slot = held_count;
      for (int i = held_count - 1; i >= 0; i--) begin
        if (held[i].prio <= req.req_priority) slot = i;
      end
      for (int i = held_count; i > slot; i--) held[i] = held[i-1];
      held[slot].tag  = req.req_id;
      held[slot].prio = req.req_priority;
      held[slot].age  = '0;
      held_count++;
      for (int i = slot + 1; i < held_count; i++) begin
        if (held[i].age >= threshold) begin
          if (held[i].prio != 8'hFF) held[i].prio = held[i].prio + 8'd1;
          held[i].age = '0;
        end else begin
          held[i].age = held[i].age + 4'd1;
        end
      end
      res.status = StatusInserted;
    end
    res.occupancy = 5'(held_count);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      threshold  = ThrReset;
      predicted_results.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result transfer: status %0d id %0d priority %0d",
                 out_data_i.status, out_data_i.out_id, out_data_i.out_priority);
          mismatches++;
        end else begin
          oldest = predicted_results.pop_front();
          check_field("status", oldest.status, out_data_i.status);
          check_field("out_id", oldest.out_id, out_data_i.out_id);
          check_field("out_priority", oldest.out_priority, out_data_i.out_priority);
          check_field("occupancy", oldest.occupancy, out_data_i.occupancy);
        end
      end
      if (in_valid_i && !in_stall_i) predicted_results.push_back(serve_request(in_data_i));
      pending_o = predicted_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_priority_queue_with_aging_top.sv -----
// ----------------------------------------------------------------------------
// tb_priority_queue_with_aging_top
// Drives requests into the priority queue with aging: a directed opening
// over empty, full, tied and saturated cases, then phases of random inserts
// and removes under changing aging thresholds, with random gaps and stalls
// and one long result hold-off. Checking is done by pqa_queue_checker.
// ----------------------------------------------------------------------------
module tb_priority_queue_with_aging_top;
  import pqa_pkg::*;

  localparam int NumPhases     = 16;
  localparam int PhaseItems    = 102;
  localparam int WatchdogLimit = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [ThrWidth-1:0] cfg_wdata_i;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int stall_left  = 0;
  bit gaps_on     = 1'b1;

  priority_queue_with_aging_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pqa_queue_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic in_t request(logic action, logic [7:0] id, logic [7:0] prio);
    in_t r;
    r.action       = action;
    r.req_id       = id;
    r.req_priority = prio;
    return r;
  endfunction

  function automatic logic [7:0] pick_priority(int mode);
    logic [7:0] p;
    case (mode)
      0: p = 8'($urandom_range(0, 255));
      1: p = 8'($urandom_range(124, 131));
      default: begin
        p = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(252, 255));
      end
    endcase
    return p;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input in_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_threshold(input logic [ThrWidth-1:0] value);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // receiver: random stall bursts plus a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else if (stall_left != 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = $urandom_range(0, 4);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int insert_pct;
    int pmode;
    in_t item;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed opening
    send_item(request(ActRemove, 8'h00, 8'h00));
    send_item(request(ActInsert, 8'h00, 8'h00));
    send_item(request(ActInsert, 8'hFF, 8'hFF));
    send_item(request(ActInsert, 8'h55, 8'hAA));
    send_item(request(ActInsert, 8'hAA, 8'h55));
    send_item(request(ActInsert, 8'h5A, 8'hAA));
    write_threshold(4'd0);
    send_item(request(ActInsert, 8'hA5, 8'hFF));
    send_item(request(ActInsert, 8'h01, 8'h00));
    write_threshold(4'd15);
    for (int k = 0; k < 9; k++) send_item(request(ActInsert, 8'(8'h10 + k), 8'hFF));
    send_item(request(ActInsert, 8'h7E, 8'h80));
    write_threshold(4'd1);
    send_item(request(ActRemove, 8'hFF, 8'hFF));
    send_item(request(ActInsert, 8'hC3, 8'hFF));

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      gaps_on = (p < NumPhases - 3);
      case (p)
        0: write_threshold(4'd15);
        1: write_threshold(4'd0);
        2: write_threshold(4'd1);
        default: write_threshold(4'($urandom_range(0, 15)));
      endcase
      case (p % 3)
        0: insert_pct = 75;
        1: insert_pct = 25;
        default: insert_pct = 50;
      endcase
      pmode = $urandom_range(0, 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 3 && n == 20) hold_cycles = 200;
        item.action       = ($urandom_range(0, 99) < insert_pct) ? ActInsert : ActRemove;
        item.req_id       = 8'($urandom_range(0, 255));
        item.req_priority = pick_priority(pmode);
        send_item(item);
      end
    end

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
